// ----- sv/msb_pkg.sv -----
// ----------------------------------------------------------------------------
// Multi-stack shared buffer package
// Item types, command and status codes, controller states and the command
// group that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package msb_pkg;

  localparam int unsigned ID_W     = 2;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic                    command;
    logic [ID_W-1:0]         stack_id;
    logic signed [VAL_W-1:0] push_value;
  } msb_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] pop_value;
    logic [STATUS_W-1:0]     status;
  } msb_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE
  } msb_state_e;

  typedef struct packed {
    logic accept;
    logic rd;
    logic commit;
  } msb_cmd_t;

endpackage

// ----- sv/msb_ctrl.sv -----
// ----------------------------------------------------------------------------
// Multi-stack shared buffer controller
// Sequences each item through accept, memory read and write back, and owns
// the valid flag of the output register.
// ----------------------------------------------------------------------------
module msb_ctrl import msb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output msb_cmd_t cmd_o
);

  msb_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_WRITE;
      end
      S_WRITE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = cmd_o.commit || (out_valid_q && out_stall_i);
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == S_READ)
    else $error("Accepted item did not move to the read step.");

  a_read_to_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> state_q == S_WRITE)
    else $error("Read step was not followed by the write step.");

  a_commit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("Committed item did not present a result.");

endmodule

// ----- sv/msb_datapath.sv -----
// ----------------------------------------------------------------------------
// Multi-stack shared buffer datapath
// Slot data, slot links and stack tops in memories, plus the free list head
// and a fill mark that stands in for the initial chaining of the links.
// ----------------------------------------------------------------------------
module msb_datapath import msb_pkg::*; #(
  parameter int unsigned NUM_STACKS = 4,
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  msb_cmd_t cmd_i,
  input  msb_in_t  in_item_i,
  output msb_out_t out_item_o
);

  localparam int unsigned LW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned AW = $clog2(NUM_SLOTS);
  localparam int unsigned SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(NUM_SLOTS);
  localparam logic [DATA_WIDTH-1:0] MAX_POS = {DATA_WIDTH{1'b1}} >> 1;

  logic [DATA_WIDTH-1:0] data_mem_q [NUM_SLOTS];
  logic [LW-1:0]         link_mem_q [NUM_SLOTS];
  logic [LW-1:0]         top_mem_q  [NUM_STACKS];

  logic [NUM_STACKS-1:0] top_vld_q, top_vld_d;
  logic [LW-1:0]         free_head_q, free_head_d;
  logic [LW-1:0]         hwm_q, hwm_d;

  logic                  op_q;
  logic                  sid_ok_q;
  logic [SW-1:0]         sid_q;
  logic [SW-1:0]         in_sid;
  logic [DATA_WIDTH-1:0] val_q;
  logic                  top_hit_q;
  logic [LW-1:0]         top_rd_q;
  logic [LW-1:0]         top_eff;

  logic [LW-1:0]         rd_ptr;
  logic                  rd_ok;
  logic                  ok_q;
  logic                  fresh_q;
  logic [AW-1:0]         addr_q;
  logic [LW-1:0]         link_rd_q;
  logic [LW-1:0]         link_val;
  logic [DATA_WIDTH-1:0] data_rd_q;
  logic signed [DATA_WIDTH-1:0] data_s;

  msb_out_t out_q, out_d;

  assign in_sid   = SW'(in_item_i.stack_id);
  assign top_eff  = top_hit_q ? top_rd_q : NULL_LINK;
  assign rd_ptr   = (op_q == CMD_PUSH) ? free_head_q : top_eff;
  assign rd_ok    = sid_ok_q && (rd_ptr != NULL_LINK);
  // A slot at or above the fill mark takes its initial link to the next slot.
  assign link_val = fresh_q ? (LW'(addr_q) + LW'(1)) : link_rd_q;
  assign data_s   = data_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q      <= in_item_i.command;
      sid_q     <= in_sid;
      sid_ok_q  <= 32'(in_item_i.stack_id) < NUM_STACKS;
      val_q     <= DATA_WIDTH'($unsigned(in_item_i.push_value));
      top_rd_q  <= top_mem_q[in_sid];
      top_hit_q <= top_vld_q[in_sid];
    end
    if (cmd_i.rd) begin
      ok_q      <= rd_ok;
      addr_q    <= rd_ptr[AW-1:0];
      fresh_q   <= rd_ptr >= hwm_q;
      link_rd_q <= link_mem_q[rd_ptr[AW-1:0]];
      data_rd_q <= data_mem_q[rd_ptr[AW-1:0]];
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && ok_q) begin
      if (op_q == CMD_PUSH) begin
        data_mem_q[addr_q] <= val_q;
        link_mem_q[addr_q] <= top_eff;
        top_mem_q[sid_q]   <= LW'(addr_q);
      end else begin
        link_mem_q[addr_q] <= free_head_q;
        top_mem_q[sid_q]   <= link_val;
      end
    end
  end

  always_comb begin
    free_head_d = free_head_q;
    hwm_d       = hwm_q;
    top_vld_d   = top_vld_q;
    if (cmd_i.commit && ok_q) begin
      top_vld_d[sid_q] = 1'b1;
      if (op_q == CMD_PUSH) begin
        free_head_d = link_val;
        if (fresh_q) begin
          hwm_d = LW'(addr_q) + LW'(1);
        end
      end else begin
        free_head_d = LW'(addr_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      hwm_q       <= '0;
      top_vld_q   <= '0;
    end else begin
      free_head_q <= free_head_d;
      hwm_q       <= hwm_d;
      top_vld_q   <= top_vld_d;
    end
  end

  always_comb begin
    out_d.pop_value = '0;
    out_d.status    = STATUS_OK;
    if (op_q == CMD_PUSH) begin
      if (!ok_q) begin
        out_d.status = STATUS_OVERFLOW;
      end
    end else if (ok_q) begin
      out_d.pop_value = 32'(data_s);
    end else begin
      out_d.pop_value = 32'(MAX_POS);
      out_d.status    = STATUS_UNDERFLOW;
    end
  end

  assign out_item_o = out_q;

  a_fill_mark_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hwm_q <= NULL_LINK)
    else $error("Fill mark passed the number of slots.");

  a_free_head_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_head_q >= hwm_q) |-> (free_head_q == hwm_q || free_head_q == NULL_LINK))
    else $error("Free list head skipped an unused slot.");

  a_pop_written_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && ok_q && op_q == CMD_POP) |-> !fresh_q)
    else $error("Pop reached a slot that no push has written.");

endmodule

// ----- sv/multi_stack_shared_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// Multi-stack shared buffer unit
// Several LIFO stacks share one slot memory, with a linked free list of
// unused slots and a link per slot that chains each stack's entries.
//
//   Channel   Direction   Payload     Handshake
//   in        input       msb_in_t    in_valid_i / in_stall_o
//   out       output      msb_out_t   out_valid_o / out_stall_i
//
// Each item goes through accept with the stack top read, the slot
// link and data read, then the write back that loads the output register.
// The steps follow the dependent chain of stack top, slot link and write back.
// A waiting result holds the write back step; the next item waits for it.
// Reset clears the free list head, the fill mark and the stack valid bits.
// The memories need no clearing pass after reset.
// ----------------------------------------------------------------------------
module multi_stack_shared_buffer_unit import msb_pkg::*; #(
  parameter int unsigned NUM_STACKS = 4,
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  msb_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output msb_out_t out_item_o
);

  msb_cmd_t cmd;

  msb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  msb_datapath #(
    .NUM_STACKS (NUM_STACKS),
    .NUM_SLOTS  (NUM_SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule

// ----- sim/tb_multi_stack_shared_buffer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-stack shared buffer unit testbench
// Drives push and pop items into the unit with random gaps and output
// stalls. A linked-list model of the slot memory, free list and stack tops
// predicts each result, and every result is compared in order.
// ----------------------------------------------------------------------------
module tb_multi_stack_shared_buffer_unit;
  import msb_pkg::*;

  localparam int unsigned NUM_STACKS     = 4;
  localparam int unsigned NUM_SLOTS      = 16;
  localparam int unsigned PTR_W          = 5;
  localparam int unsigned IDX_W          = 4;
  localparam logic [PTR_W-1:0] NULL_PTR  = PTR_W'(NUM_SLOTS);
  localparam logic signed [VAL_W-1:0] MAX_POS = {1'b0, {(VAL_W-1){1'b1}}};
  localparam int unsigned LATENCY_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  msb_in_t  in_item   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  msb_out_t out_item;

  logic [VAL_W-1:0] slot_val  [NUM_SLOTS];
  logic [PTR_W-1:0] slot_next [NUM_SLOTS];
  logic [PTR_W-1:0] top_ptr   [NUM_STACKS];
  logic [PTR_W-1:0] free_ptr;
  int unsigned      depth     [NUM_STACKS];
  int unsigned      used_slots;
  msb_out_t         pop_results_q [$];

  bit          sender_idle_en   = 1'b0;
  bit          receiver_idle_en = 1'b0;
  int unsigned hold_cycles      = 0;
  int unsigned stall_left       = 0;
  int unsigned error_count      = 0;
  int unsigned cycle_count      = 0;

  multi_stack_shared_buffer_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic init_model();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_val[IDX_W'(i)]  = '0;
      slot_next[IDX_W'(i)] = PTR_W'(i + 1);
    end
    for (int s = 0; s < NUM_STACKS; s++) begin
      top_ptr[ID_W'(s)] = NULL_PTR;
      depth[ID_W'(s)]   = 0;
    end
    free_ptr   = '0;
    used_slots = 0;
  endtask

  function automatic msb_out_t apply_stack_op(msb_in_t op);
    msb_out_t         res;
    logic [PTR_W-1:0] slot;
    logic [IDX_W-1:0] idx;
    res.pop_value = '0;
    res.status    = STATUS_OK;
    if (op.command == CMD_PUSH) begin
      slot = free_ptr;
      idx  = slot[IDX_W-1:0];
      if (op.stack_id >= NUM_STACKS || slot >= NUM_SLOTS) begin
        res.status = STATUS_OVERFLOW;
      end else begin
        free_ptr             = (slot_next[idx] < NUM_SLOTS) ? slot_next[idx] : NULL_PTR;
        slot_next[idx]       = top_ptr[op.stack_id];
        top_ptr[op.stack_id] = slot;
        slot_val[idx]        = op.push_value;
        depth[op.stack_id]++;
        used_slots++;
      end
    end else begin
      slot = (op.stack_id < NUM_STACKS) ? top_ptr[op.stack_id] : NULL_PTR;
      idx  = slot[IDX_W-1:0];
      if (slot >= NUM_SLOTS) begin
        res.status    = STATUS_UNDERFLOW;
        res.pop_value = MAX_POS;
      end else begin
        top_ptr[op.stack_id] = (slot_next[idx] < NUM_SLOTS) ? slot_next[idx] : NULL_PTR;
        slot_next[idx]       = (free_ptr < NUM_SLOTS) ? free_ptr : NULL_PTR;
        free_ptr             = slot;
        res.pop_value        = slot_val[idx];
        depth[op.stack_id]--;
        used_slots--;
      end
    end
    return res;
  endfunction

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if (receiver_idle_en && $urandom_range(3) == 0) begin
      stall_left = $urandom_range(5, 1) - 1;
      out_stall  = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    msb_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pop_results_q.size() == 0) begin
        $error("Unexpected result: pop_value %0d, status %0d", out_item.pop_value,
               out_item.status);
        error_count++;
      end else begin
        want = pop_results_q.pop_front();
        if (out_item.pop_value !== want.pop_value) begin
          $error("pop_value: expected %0d, actual %0d", want.pop_value, out_item.pop_value);
          error_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_item.status);
          error_count++;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_op(input logic cmd, input logic [ID_W-1:0] sid,
                         input logic [VAL_W-1:0] val);
    if (sender_idle_en && $urandom_range(3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(5, 1)) @(negedge clk);
    end
    in_item.command    = cmd;
    in_item.stack_id   = sid;
    in_item.push_value = val;
    in_valid           = 1'b1;
    do @(posedge clk); while (in_stall);
    pop_results_q.push_back(apply_stack_op(in_item));
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned push_pct);
    logic [ID_W-1:0] sid;
    sid = ID_W'($urandom_range(NUM_STACKS - 1));
    if ($urandom_range(99) < push_pct) begin
      send_op(CMD_PUSH, sid, $urandom);
    end else begin
      if (used_slots != 0 && $urandom_range(3) != 0) begin
        while (depth[sid] == 0) sid = ID_W'($urandom_range(NUM_STACKS - 1));
      end
      send_op(CMD_POP, sid, $urandom);
    end
  endtask

  task automatic wait_drained();
    while (pop_results_q.size() != 0) @(negedge clk);
    repeat (LATENCY_CYCLES) @(negedge clk);
  endtask

  task automatic test_extremes();
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    send_op(CMD_PUSH, 2'd0, 32'h8000_0000);
    send_op(CMD_PUSH, 2'd1, 32'h7FFF_FFFF);
    send_op(CMD_PUSH, 2'd2, 32'h0000_0000);
    send_op(CMD_PUSH, 2'd3, 32'hFFFF_FFFF);
    send_op(CMD_PUSH, 2'd0, 32'h5555_5555);
    send_op(CMD_PUSH, 2'd0, 32'hAAAA_AAAA);
    for (int s = 0; s < NUM_STACKS; s++) send_op(CMD_POP, ID_W'(s), $urandom);
    send_op(CMD_POP, 2'd0, 32'hFFFF_FFFF);
    send_op(CMD_POP, 2'd0, 32'h0000_0000);
    for (int s = 0; s < NUM_STACKS; s++) send_op(CMD_POP, ID_W'(s), $urandom);
    in_valid = 1'b0;
  endtask

  // Phases lean toward pushes or pops, or mix the two, so that the buffer fills
  // to overflow and drains to underflow again and again.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned phase_len;
    int unsigned push_pct;
    sent = 0;
    while (sent < n_items) begin
      phase_len = $urandom_range(60, 10);
      case ($urandom_range(3))
        0:       push_pct = 85;
        1:       push_pct = 15;
        2:       push_pct = 50;
        default: push_pct = $urandom_range(100);
      endcase
      sender_idle_en   = ($urandom_range(3) != 0);
      receiver_idle_en = ($urandom_range(3) != 0);
      repeat (phase_len) send_random(push_pct);
      sent += phase_len;
    end
    in_valid = 1'b0;
  endtask

  task automatic test_output_hold();
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    hold_cycles      = 100;
    repeat (40) send_random(50);
    in_valid = 1'b0;
  endtask

  task automatic test_pause_until_empty();
    sender_idle_en   = 1'b1;
    receiver_idle_en = 1'b1;
    repeat (20) send_random(60);
    in_valid = 1'b0;
    wait_drained();
    repeat (20) send_random(40);
    in_valid = 1'b0;
  endtask

  task automatic test_steady_stream(input int unsigned n_items);
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    for (int i = 0; i < n_items; i += 50) begin
      repeat (50) send_random($urandom_range(90, 10));
    end
    in_valid = 1'b0;
  endtask

  initial begin
    init_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_extremes();
    test_random_traffic(1500);
    test_output_hold();
    test_pause_until_empty();
    test_steady_stream(350);
    wait_drained();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
